### rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue unit.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package spq_pkg;

   localparam int CAPACITY  = 16;
   localparam int TAG_WIDTH = 16;

   localparam int TAG_IN_W    = 16;
   localparam int PRIO_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 5;

   // Only the low TAG_WIDTH bits of the 16-bit tag field are kept.
   localparam int STORED_TAG_W = (TAG_WIDTH < TAG_IN_W) ? TAG_WIDTH : TAG_IN_W;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   localparam logic ACT_ENQ = 1'b0;
   localparam logic ACT_DEQ = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [PRIO_W-1:0]       prio;
      logic [STORED_TAG_W-1:0] tag;
   } entry_type;

endpackage

`default_nettype wire

### rtl/spq_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on spq_pkg for field widths.
`default_nettype none

interface spq_req_if;
   import spq_pkg::*;

   logic              valid;
   logic              ready;
   logic              action;
   logic [TAG_IN_W-1:0] item_tag;
   logic [PRIO_W-1:0] priority_req;

   modport source (output valid, output action, output item_tag, output priority_req,
                   input ready);
   modport sink (input valid, input action, input item_tag, input priority_req,
                 output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [TAG_IN_W-1:0]    out_tag;
   logic [PRIO_W-1:0]      out_priority;
   logic                   out_valid;
   logic [STATUS_W-1:0]    status;
   logic [COUNT_OUT_W-1:0] entry_count;

   modport source (output valid, output out_tag, output out_priority, output out_valid,
                   output status, output entry_count, input ready);
   modport sink (input valid, input out_tag, input out_priority, input out_valid,
                 input status, input entry_count, output ready);
endinterface

`default_nettype wire

### rtl/sorted_priority_queue_unit.sv
// Sorted priority queue: sequencer, entry memory and shared priority compare.
// Depends on spq_pkg and the channel interfaces in spq_if.sv.
//
// Usage: each request beat on req_chan is either an enqueue (priority and tag)
// or a dequeue. Every request produces exactly one response beat on rsp_chan
// carrying the dequeued entry (or zeros), a status code and the entry count
// after the operation. Entries leave in descending priority; equal priorities
// leave in arrival order.
//
// The entries live in a single-port-write, registered-read memory kept sorted
// with slot 0 at the head. One comparator and the memory port are reused every
// cycle: an enqueue walks from the tail toward the head, moving one entry down
// per cycle until it finds an entry of equal or higher priority. A dequeue
// reads the head, then moves every remaining entry up one slot per cycle.
// An enqueue into a full or empty store, or a dequeue from an empty one, skips
// the walk. Ready returns in the cycle the response appears.
// A new request is accepted only while the sequencer is idle; it may be taken
// while the previous response still waits, and the sequencer then holds the
// new result until the receiver drains the output register.
// Synchronous reset empties the queue; the memory contents are not cleared,
// since data read from slots at or above the count is never used.
`default_nettype none

module sorted_priority_queue_unit (
   input  wire logic clock,
   input  wire logic reset,
   spq_req_if.sink   req_chan,
   spq_rsp_if.source rsp_chan
);
   import spq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ENQ_CMP,
      S_ENQ_LAST,
      S_DEQ_HEAD,
      S_DEQ_MV,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [PRIO_W-1:0]       prio_ff, prio_in;
   logic [STORED_TAG_W-1:0] tag_ff, tag_in;

   logic [STORED_TAG_W-1:0] res_tag_ff, res_tag_in;
   logic [PRIO_W-1:0]       res_prio_ff, res_prio_in;
   logic                    res_valid_ff, res_valid_in;
   logic [STATUS_W-1:0]     res_status_ff, res_status_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [TAG_IN_W-1:0]     out_tag_ff, out_tag_in;
   logic [PRIO_W-1:0]       out_prio_ff, out_prio_in;
   logic                    out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [COUNT_OUT_W-1:0]  entry_count_ff, entry_count_in;

   // Entry memory: one write and one registered read per cycle.
   entry_type         mem [CAPACITY];
   entry_type         rd_data_ff;
   entry_type         wr_data;
   logic              wr_en;
   logic [CNT_W-1:0]  rd_ptr;
   logic [CNT_W-1:0]  wr_ptr;
   logic              rsp_free;
   logic              req_fire;
   logic              prio_ge;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr[ADDR_W-1:0]] <= wr_data;
      end
      rd_data_ff <= mem[rd_ptr[ADDR_W-1:0]];
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   // The shared compare: a stored entry stays ahead when its priority is at
   // least the new one.
   assign prio_ge = (rd_data_ff.prio >= prio_ff);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      prio_in        = prio_ff;
      tag_in         = tag_ff;
      res_tag_in     = res_tag_ff;
      res_prio_in    = res_prio_ff;
      res_valid_in   = res_valid_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      out_tag_in     = out_tag_ff;
      out_prio_in    = out_prio_ff;
      out_valid_in   = out_valid_ff;
      status_in      = status_ff;
      entry_count_in = entry_count_ff;
      wr_en          = 1'b0;
      wr_ptr         = '0;
      wr_data        = '{prio: prio_ff, tag: tag_ff};
      rd_ptr         = '0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.action == ACT_ENQ) begin
               rd_ptr = count_ff - CNT_W'(1);
            end
            if (req_fire) begin
               prio_in       = req_chan.priority_req;
               tag_in        = req_chan.item_tag[STORED_TAG_W-1:0];
               res_tag_in    = '0;
               res_prio_in   = '0;
               res_valid_in  = 1'b0;
               res_status_in = STATUS_OK;
               if (req_chan.action == ACT_ENQ) begin
                  if (count_ff == CAP_CNT) begin
                     res_status_in = STATUS_FULL;
                     state_in      = S_DONE;
                  end else if (count_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_ptr   = '0;
                     wr_data  = '{prio: req_chan.priority_req,
                                  tag: req_chan.item_tag[STORED_TAG_W-1:0]};
                     count_in = count_ff + CNT_W'(1);
                     state_in = S_DONE;
                  end else begin
                     idx_in   = count_ff - CNT_W'(1);
                     state_in = S_ENQ_CMP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_status_in = STATUS_EMPTY;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_DEQ_HEAD;
                  end
               end
            end
         end

         S_ENQ_CMP: begin
            // Read the next slot toward the head while this one is decided.
            rd_ptr = idx_ff - CNT_W'(1);
            wr_en  = 1'b1;
            wr_ptr = idx_ff + CNT_W'(1);
            if (prio_ge) begin
               count_in = count_ff + CNT_W'(1);
               state_in = S_DONE;
            end else begin
               wr_data = rd_data_ff;
               if (idx_ff == '0) begin
                  state_in = S_ENQ_LAST;
               end else begin
                  idx_in = idx_ff - CNT_W'(1);
               end
            end
         end

         S_ENQ_LAST: begin
            wr_en    = 1'b1;
            wr_ptr   = '0;
            count_in = count_ff + CNT_W'(1);
            state_in = S_DONE;
         end

         S_DEQ_HEAD: begin
            rd_ptr       = CNT_W'(1);
            res_tag_in   = rd_data_ff.tag;
            res_prio_in  = rd_data_ff.prio;
            res_valid_in = 1'b1;
            if (count_ff == CNT_W'(1)) begin
               count_in = '0;
               state_in = S_DONE;
            end else begin
               idx_in   = CNT_W'(1);
               state_in = S_DEQ_MV;
            end
         end

         S_DEQ_MV: begin
            rd_ptr  = idx_ff + CNT_W'(1);
            wr_en   = 1'b1;
            wr_ptr  = idx_ff - CNT_W'(1);
            wr_data = rd_data_ff;
            if (idx_ff == count_ff - CNT_W'(1)) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end

         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               out_tag_in     = TAG_IN_W'(res_tag_ff);
               out_prio_in    = res_prio_ff;
               out_valid_in   = res_valid_ff;
               status_in      = res_status_ff;
               entry_count_in = COUNT_OUT_W'(count_ff);
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff         <= idx_in;
      prio_ff        <= prio_in;
      tag_ff         <= tag_in;
      res_tag_ff     <= res_tag_in;
      res_prio_ff    <= res_prio_in;
      res_valid_ff   <= res_valid_in;
      res_status_ff  <= res_status_in;
      out_tag_ff     <= out_tag_in;
      out_prio_ff    <= out_prio_in;
      out_valid_ff   <= out_valid_in;
      status_ff      <= status_in;
      entry_count_ff <= entry_count_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_tag      = out_tag_ff;
   assign rsp_chan.out_priority = out_prio_ff;
   assign rsp_chan.out_valid    = out_valid_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.entry_count  = entry_count_ff;

   // The stored count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count exceeds capacity");

   // A full report only happens with a full store.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == STATUS_FULL)
         |-> rsp_chan.entry_count == COUNT_OUT_W'(CAPACITY))
      else $error("full status with store not full");

   // A returned entry always comes with an ok status.
   a_valid_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.out_valid) |-> rsp_chan.status == STATUS_OK)
      else $error("returned entry with error status");

   // Once a request is taken, the sequencer is busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_chan.ready)
      else $error("ready right after an accepted request");

   // The memory is never written while the sequencer is parked waiting.
   a_no_write_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> !wr_en)
      else $error("memory write while waiting to respond");

endmodule

`default_nettype wire

### bench/sorted_priority_queue_unit_tb.sv
// Self-checking bench for sorted_priority_queue_unit: directed and random beats.
// Every response is checked against a sorted-store predictor kept in this bench.
// Depends on spq_pkg (rtl/spq_pkg.sv) and the channel interfaces in rtl/spq_if.sv.

module sorted_priority_queue_unit_tb;
   import spq_pkg::*;

   // 1050 request beats in total, directed rows included.
   localparam int TOTAL_REQUESTS = 1050;
   // The slowest operation walks the whole store, so the tail wait after the
   // last response is long enough to catch a stray extra beat.
   localparam int TAIL_CYCLES    = 40;
   localparam int TIMEOUT_CYCLES = 200_000;
   localparam int REPORT_LIMIT   = 10;

   // One response beat, laid out the way the bench compares it.
   typedef struct packed {
      logic [TAG_IN_W-1:0]    tag;
      logic [PRIO_W-1:0]      prio;
      logic                   found;
      logic [STATUS_W-1:0]    status;
      logic [COUNT_OUT_W-1:0] count;
   } queue_result_t;

   // A response that the directed table types in by hand, or a marker that
   // the predictor's answer is the one to check against.
   typedef struct packed {
      bit            pinned;
      queue_result_t value;
   } pinned_result_t;

   typedef struct {
      logic                act;
      logic [TAG_IN_W-1:0] tag;
      logic [PRIO_W-1:0]   prio;
      bit                  pinned;
      queue_result_t       want;
   } script_row_t;

   logic clock;
   logic reset;

   spq_req_if req_bus ();
   spq_rsp_if rsp_bus ();

   sorted_priority_queue_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Predictor state: a copy of the sorted store, head at index zero.
   entry_type   held_entries [CAPACITY];
   int unsigned held_count;

   // Scoreboard: typed-in results in request order, and the results that
   // the accepted requests are still owed.
   pinned_result_t pinned_q [$];
   queue_result_t  owed_results [$];
   script_row_t    script [$];

   int items_sent;
   int responses_seen;
   int error_count;

   // Coverage tallies reported in the summary.
   int enqueues_seen;
   int dequeues_seen;
   int full_rejects;
   int empty_dequeues;
   int deepest_store;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one request to the predictor's store and return the response
   // that the block owes for it. An enqueue slides past every entry of equal
   // or higher priority, which keeps ties in arrival order.
   function automatic queue_result_t serve_request(logic act, logic [TAG_IN_W-1:0] tag,
                                                   logic [PRIO_W-1:0] prio);
      queue_result_t r;
      int unsigned   slot;
      int unsigned   i;
      r = '0;
      if (act == ACT_ENQ) begin
         if (held_count >= CAPACITY) begin
            r.status = STATUS_FULL;
         end else begin
            slot = 0;
            while (slot < held_count && held_entries[slot].prio >= prio) slot++;
            for (i = held_count; i > slot; i--) held_entries[i] = held_entries[i-1];
            held_entries[slot].prio = prio;
            held_entries[slot].tag  = tag[STORED_TAG_W-1:0];
            held_count++;
         end
      end else if (held_count == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         r.tag   = TAG_IN_W'(held_entries[0].tag);
         r.prio  = held_entries[0].prio;
         r.found = 1'b1;
         for (i = 1; i < held_count; i++) held_entries[i-1] = held_entries[i];
         held_count--;
      end
      r.count = COUNT_OUT_W'(held_count);
      return r;
   endfunction

   function automatic queue_result_t make_result(logic [TAG_IN_W-1:0] tag,
                                                 logic [PRIO_W-1:0] prio, logic found,
                                                 logic [STATUS_W-1:0] status,
                                                 logic [COUNT_OUT_W-1:0] count);
      queue_result_t r;
      r.tag    = tag;
      r.prio   = prio;
      r.found  = found;
      r.status = status;
      r.count  = count;
      return r;
   endfunction

   task automatic add_row(logic act, logic [TAG_IN_W-1:0] tag, logic [PRIO_W-1:0] prio,
                          bit pinned = 1'b0, queue_result_t want = '0);
      script_row_t row;
      row.act    = act;
      row.tag    = tag;
      row.prio   = prio;
      row.pinned = pinned;
      row.want   = want;
      script.push_back(row);
   endtask

   task automatic note_failure(string what, queue_result_t want, queue_result_t got);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("[%0t] %s", $realtime, what);
         $display("   expected tag=%h prio=%h valid=%b status=%0d count=%0d",
                  want.tag, want.prio, want.found, want.status, want.count);
         $display("   actual   tag=%h prio=%h valid=%b status=%0d count=%0d",
                  got.tag, got.prio, got.found, got.status, got.count);
      end
   endtask

   // Drive one request beat. When asked to drain, the sender first idles until
   // every response owed so far has come back, and then for the drawn gap.
   // valid is only lowered when a gap or a drain follows, so a back-to-back beat
   // never sees valid dropped and raised in the same time step.
   task automatic send_request(logic act, logic [TAG_IN_W-1:0] tag, logic [PRIO_W-1:0] prio,
                               int gap, bit drain_first, bit pinned, queue_result_t want);
      pinned_result_t pin;
      if (gap > 0 || drain_first) begin
         req_bus.valid <= 1'b0;
         if (drain_first) begin
            do @(posedge clock); while (responses_seen < items_sent);
         end
         repeat (gap) @(posedge clock);
      end
      pin.pinned = pinned;
      pin.value  = want;
      pinned_q.push_back(pin);
      req_bus.valid        <= 1'b1;
      req_bus.action       <= act;
      req_bus.item_tag     <= tag;
      req_bus.priority_req <= prio;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      items_sent++;
   endtask

   // Monitor: both channels are sampled at the rising edge, in one process,
   // so a request is always scored before any response in the same cycle.
   always @(posedge clock) begin : monitor
      pinned_result_t pin;
      queue_result_t  predicted;
      queue_result_t  got;
      queue_result_t  want;
      if (!reset) begin
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            pin = pinned_q.pop_front();
            predicted = serve_request(req_bus.action, req_bus.item_tag,
                                      req_bus.priority_req);
            if (req_bus.action == ACT_ENQ) enqueues_seen++;
            else dequeues_seen++;
            if (predicted.status == STATUS_FULL) full_rejects++;
            if (predicted.status == STATUS_EMPTY) empty_dequeues++;
            if (held_count > deepest_store) deepest_store = held_count;
            owed_results.push_back(pin.pinned ? pin.value : predicted);
         end
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got = make_result(rsp_bus.out_tag, rsp_bus.out_priority, rsp_bus.out_valid,
                              rsp_bus.status, rsp_bus.entry_count);
            responses_seen++;
            if (owed_results.size() == 0) begin
               note_failure("response beat with no request waiting", '0, got);
            end else begin
               want = owed_results.pop_front();
               if (got.tag !== want.tag || got.prio !== want.prio ||
                   got.found !== want.found || got.status !== want.status ||
                   got.count !== want.count)
                  note_failure("response beat mismatch", want, got);
            end
         end
      end
   end

   // Receiver: may hold ready low before each beat, with stretches of
   // 40 beats in which it keeps ready high throughout.
   initial begin : receiver
      int stall;
      int beat;
      bit calm;
      beat = 0;
      calm = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         if (beat % 40 == 0) calm = ($urandom_range(0, 2) == 0);
         stall = calm ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         beat++;
      end
   end

   initial begin : stimulus
      int                  seg;
      int                  seg_len;
      int                  k;
      int                  bias;
      int                  gap;
      bit                  eager;
      logic                act;
      logic [TAG_IN_W-1:0] tag;
      logic [PRIO_W-1:0]   prio;

      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.action       = ACT_ENQ;
      req_bus.item_tag     = '0;
      req_bus.priority_req = '0;
      held_count     = 0;
      items_sent     = 0;
      responses_seen = 0;
      error_count    = 0;
      enqueues_seen  = 0;
      dequeues_seen  = 0;
      full_rejects   = 0;
      empty_dequeues = 0;
      deepest_store  = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A dequeue straight after reset finds the store empty.
      add_row(ACT_DEQ, 16'h0000, 32'h0000_0000, 1'b1,
              make_result('0, '0, 1'b0, STATUS_EMPTY, 5'd0));
      // Fill the store: both priority extremes, ties at the top, the bottom
      // and the middle (which must leave in arrival order), and both tag
      // extremes. The first one lands in an empty store.
      add_row(ACT_ENQ, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
              make_result('0, '0, 1'b0, STATUS_OK, 5'd1));
      add_row(ACT_ENQ, 16'h0000, 32'h0000_0000);
      add_row(ACT_ENQ, 16'h1234, 32'h8000_0000);
      add_row(ACT_ENQ, 16'h5678, 32'h8000_0000);
      add_row(ACT_ENQ, 16'h9ABC, 32'h8000_0000);
      add_row(ACT_ENQ, 16'h0001, 32'h0000_0000);
      add_row(ACT_ENQ, 16'h0002, 32'hFFFF_FFFF);
      add_row(ACT_ENQ, 16'h00FF, 32'h0000_0001);
      add_row(ACT_ENQ, 16'hFF00, 32'hFFFF_FFFE);
      add_row(ACT_ENQ, 16'h8000, 32'h7FFF_FFFF);
      add_row(ACT_ENQ, 16'h5555, 32'h5555_5555);
      add_row(ACT_ENQ, 16'hAAAA, 32'hAAAA_AAAA);
      add_row(ACT_ENQ, 16'h0F0F, 32'h8000_0001);
      add_row(ACT_ENQ, 16'hF0F0, 32'h0000_FFFF);
      add_row(ACT_ENQ, 16'h3C3C, 32'hFFFF_0000);
      add_row(ACT_ENQ, 16'hC3C3, 32'h8000_0000);
      // The store is full now, so even a top priority is turned away.
      add_row(ACT_ENQ, 16'h7777, 32'hFFFF_FFFF, 1'b1,
              make_result('0, '0, 1'b0, STATUS_FULL, 5'd16));
      // The oldest of the two top-priority entries leaves first.
      add_row(ACT_DEQ, 16'h0000, 32'h0000_0000, 1'b1,
              make_result(16'hFFFF, 32'hFFFF_FFFF, 1'b1, STATUS_OK, 5'd15));
      repeat (4) add_row(ACT_DEQ, 16'hFFFF, 32'hFFFF_FFFF);

      foreach (script[n])
         send_request(script[n].act, script[n].tag, script[n].prio, $urandom_range(0, 3),
                      1'b0, script[n].pinned, script[n].want);

      // Random part, in segments. Each segment leans toward enqueues or
      // dequeues or mixes them evenly, so the store swings between empty and full many times.
      // Priorities mix full-range values with a narrow band that forces ties.
      // Every fourth segment starts with the sender held off until every
      // owed response has come back.
      seg = 0;
      while (items_sent < TOTAL_REQUESTS) begin
         seg_len = $urandom_range(20, 80);
         eager   = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 4))
            0: bias = 90;
            1: bias = 70;
            2: bias = 50;
            3: bias = 30;
            default: bias = 10;
         endcase
         for (k = 0; k < seg_len && items_sent < TOTAL_REQUESTS; k++) begin
            act = ($urandom_range(0, 99) < bias) ? ACT_ENQ : ACT_DEQ;
            tag = TAG_IN_W'($urandom);
            case ($urandom_range(0, 9))
               0, 1, 2: prio = $urandom;
               3, 4, 5: prio = $urandom_range(0, 7);
               6:       prio = '0;
               7:       prio = '1;
               8:       prio = {16'hFFFF, 16'($urandom)};
               default: prio = 32'($urandom_range(0, 3)) << 30;
            endcase
            gap = eager ? 0 : $urandom_range(0, 3);
            send_request(act, tag, prio, gap, (seg % 4 == 3) && (k == 0), 1'b0, '0);
         end
         seg++;
      end

      req_bus.valid <= 1'b0;
      do @(posedge clock); while (responses_seen < items_sent);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (owed_results.size() != 0) error_count++;

      $display("Covered %0d request beats: %0d enqueues (%0d refused as full), %0d dequeues",
               items_sent, enqueues_seen, full_rejects, dequeues_seen);
      $display("(%0d on an empty store); deepest store %0d of %0d; %0d mismatches",
               empty_dequeues, deepest_store, CAPACITY, error_count);
      if (error_count == 0) begin
         $display("sorted_priority_queue_unit verification clean");
      end else begin
         $display("sorted_priority_queue_unit verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run, so only a hang trips it.
   initial begin : watchdog
      #(TIMEOUT_CYCLES * 10);
      $display("sorted_priority_queue_unit verification failed");
      $finish;
   end

endmodule
